FILE: rtl/cia_pkg.sv
// Shared types and constants of the complex integer ALU.
// Used by every module in rtl; depends on nothing.
package cia_pkg;

  localparam int OpW     = 16;          // Width of each operand part.
  localparam int ProdW   = 2 * OpW;     // Width of one signed product.
  localparam int SumW    = 2 * OpW + 2; // Width of a signed sum of two products.
  localparam int MagW    = 2 * OpW;     // Magnitudes never exceed 2**(2*OpW-1).
  localparam int ResW    = 32;
  localparam int DivStages = MagW;

  typedef enum logic [2:0] {
    FUNC_ADD  = 3'd0,
    FUNC_SUB  = 3'd1,
    FUNC_MUL  = 3'd2,
    FUNC_DIV  = 3'd3,
    FUNC_SMUL = 3'd4,
    FUNC_SDIV = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_DZ  = 2'd1,
    STAT_SAT = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]            func;
    logic signed [OpW-1:0] a_real;
    logic signed [OpW-1:0] a_imag;
    logic signed [OpW-1:0] b_real;
    logic signed [OpW-1:0] b_imag;
    logic signed [OpW-1:0] scalar;
  } cia_in_t;

  typedef struct packed {
    logic signed [ResW-1:0] res_real;
    logic signed [ResW-1:0] res_imag;
    logic [1:0]             status;
  } cia_out_t;

  // Sign-magnitude item handed from the front end to the divider.
  typedef struct packed {
    logic            dz;
    logic            neg_re;
    logic [MagW-1:0] mag_re;
    logic            neg_im;
    logic [MagW-1:0] mag_im;
    logic [MagW-1:0] den;
  } sm_item_t;

  // Quotient item handed from the divider to the output stage.
  typedef struct packed {
    logic            dz;
    logic            neg_re;
    logic [MagW-1:0] q_re;
    logic            neg_im;
    logic [MagW-1:0] q_im;
  } quot_item_t;

endpackage

FILE: rtl/cia_front.sv
// Front end: input register, product stage and sum/magnitude stage.
// Depends on cia_pkg.
module cia_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  cia_pkg::cia_in_t  item_i,
  output logic              vld_o,
  output cia_pkg::sm_item_t sm_o
);
  import cia_pkg::*;

  cia_in_t in_q;
  logic    vld_a_q, vld_b_q, vld_c_q;

  cia_in_t                 in_b_q;
  logic signed [ProdW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_bb_q, p_ss_q;
  logic signed [OpW-1:0]   bop;

  sm_item_t sm_d, sm_q;

  // For scale multiply the scalar takes the place of b_real.
  assign bop = (in_q.func == FUNC_SMUL) ? in_q.scalar : in_q.b_real;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= item_i;
    in_b_q <= in_q;
    p_rr_q <= in_q.a_real * bop;
    p_ii_q <= in_q.a_imag * in_q.b_imag;
    p_ri_q <= in_q.a_real * in_q.b_imag;
    p_ir_q <= in_q.a_imag * bop;
    p_bb_q <= in_q.b_real * in_q.b_real;
    p_ss_q <= in_q.b_imag * in_q.b_imag;
    sm_q   <= sm_d;
  end

  logic signed [SumW-1:0] re_v, im_v, s_ext;
  logic [MagW-1:0]        abs_s, den_c;

  always_comb begin
    s_ext = SumW'(in_b_q.scalar);
    abs_s = MagW'(s_ext[SumW-1] ? -s_ext : s_ext);
    den_c = MagW'($unsigned(p_bb_q)) + MagW'($unsigned(p_ss_q));
    re_v  = '0;
    im_v  = '0;
    sm_d  = '0;
    sm_d.den = MagW'(1);
    case (func_e'(in_b_q.func))
      FUNC_ADD: begin
        re_v = SumW'(in_b_q.a_real) + SumW'(in_b_q.b_real);
        im_v = SumW'(in_b_q.a_imag) + SumW'(in_b_q.b_imag);
      end
      FUNC_SUB: begin
        re_v = SumW'(in_b_q.a_real) - SumW'(in_b_q.b_real);
        im_v = SumW'(in_b_q.a_imag) - SumW'(in_b_q.b_imag);
      end
      FUNC_MUL: begin
        re_v = SumW'(p_rr_q) - SumW'(p_ii_q);
        im_v = SumW'(p_ri_q) + SumW'(p_ir_q);
      end
      FUNC_DIV: begin
        if (den_c == '0) begin
          sm_d.dz = 1'b1;
        end else begin
          re_v = SumW'(p_rr_q) + SumW'(p_ii_q);
          im_v = SumW'(p_ir_q) - SumW'(p_ri_q);
          sm_d.den = den_c;
        end
      end
      FUNC_SMUL: begin
        re_v = SumW'(p_rr_q);
        im_v = SumW'(p_ir_q);
      end
      FUNC_SDIV: begin
        if (abs_s == '0) begin
          sm_d.dz = 1'b1;
        end else begin
          // The divider works on magnitudes, so a negative scalar flips the dividend.
          re_v = s_ext[SumW-1] ? -SumW'(in_b_q.a_real) : SumW'(in_b_q.a_real);
          im_v = s_ext[SumW-1] ? -SumW'(in_b_q.a_imag) : SumW'(in_b_q.a_imag);
          sm_d.den = abs_s;
        end
      end
      default: ;
    endcase
    sm_d.neg_re = re_v[SumW-1];
    sm_d.mag_re = MagW'(re_v[SumW-1] ? -re_v : re_v);
    sm_d.neg_im = im_v[SumW-1];
    sm_d.mag_im = MagW'(im_v[SumW-1] ? -im_v : im_v);
  end

  assign vld_o = vld_c_q;
  assign sm_o  = sm_q;

endmodule

FILE: rtl/cia_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing
// one divisor. Depends on cia_pkg.
module cia_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  cia_pkg::sm_item_t   sm_i,
  output logic                vld_o,
  output cia_pkg::quot_item_t quot_o
);
  import cia_pkg::*;

  logic            vld_q    [DivStages+1];
  logic            dz_q     [DivStages+1];
  logic            neg_re_q [DivStages+1];
  logic            neg_im_q [DivStages+1];
  logic [MagW-1:0] rem_re_q [DivStages+1];
  logic [MagW-1:0] rem_im_q [DivStages+1];
  logic [MagW-1:0] num_re_q [DivStages+1];
  logic [MagW-1:0] num_im_q [DivStages+1];
  logic [MagW-1:0] den_q    [DivStages+1];

  assign vld_q[0]    = vld_i;
  assign dz_q[0]     = sm_i.dz;
  assign neg_re_q[0] = sm_i.neg_re;
  assign neg_im_q[0] = sm_i.neg_im;
  assign rem_re_q[0] = '0;
  assign rem_im_q[0] = '0;
  assign num_re_q[0] = sm_i.mag_re;
  assign num_im_q[0] = sm_i.mag_im;
  assign den_q[0]    = sm_i.den;

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic [MagW:0] sh_re, sh_im;
    logic          ge_re, ge_im;

    // The remainder stays below the divisor, so the shifted value fits MagW+1 bits.
    assign sh_re = {rem_re_q[k], num_re_q[k][MagW-1]};
    assign sh_im = {rem_im_q[k], num_im_q[k][MagW-1]};
    assign ge_re = sh_re >= {1'b0, den_q[k]};
    assign ge_im = sh_im >= {1'b0, den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dz_q[k+1]     <= dz_q[k];
      neg_re_q[k+1] <= neg_re_q[k];
      neg_im_q[k+1] <= neg_im_q[k];
      den_q[k+1]    <= den_q[k];
      rem_re_q[k+1] <= MagW'(ge_re ? sh_re - {1'b0, den_q[k]} : sh_re);
      rem_im_q[k+1] <= MagW'(ge_im ? sh_im - {1'b0, den_q[k]} : sh_im);
      num_re_q[k+1] <= {num_re_q[k][MagW-2:0], ge_re};
      num_im_q[k+1] <= {num_im_q[k][MagW-2:0], ge_im};
    end
  end

  assign vld_o         = vld_q[DivStages];
  assign quot_o.dz     = dz_q[DivStages];
  assign quot_o.neg_re = neg_re_q[DivStages];
  assign quot_o.neg_im = neg_im_q[DivStages];
  assign quot_o.q_re   = num_re_q[DivStages];
  assign quot_o.q_im   = num_im_q[DivStages];

endmodule

FILE: rtl/cia_sat.sv
// Output stage: sign restore, 32-bit saturation and status encoding.
// Depends on cia_pkg.
module cia_sat (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  cia_pkg::quot_item_t quot_i,
  output logic                vld_o,
  output cia_pkg::cia_out_t   res_o
);
  import cia_pkg::*;

  logic     vld_q;
  cia_out_t res_d, res_q;
  logic     sat_re, sat_im;

  // A negative magnitude never exceeds 2**31, so only the positive side clamps.
  assign sat_re = !quot_i.neg_re && quot_i.q_re[MagW-1];
  assign sat_im = !quot_i.neg_im && quot_i.q_im[MagW-1];

  always_comb begin
    res_d = '0;
    if (quot_i.dz) begin
      res_d.status = STAT_DZ;
    end else begin
      res_d.res_real = sat_re ? {1'b0, {(ResW-1){1'b1}}} :
                       quot_i.neg_re ? ResW'(-quot_i.q_re) : ResW'(quot_i.q_re);
      res_d.res_imag = sat_im ? {1'b0, {(ResW-1){1'b1}}} :
                       quot_i.neg_im ? ResW'(-quot_i.q_im) : ResW'(quot_i.q_im);
      res_d.status   = (sat_re || sat_im) ? STAT_SAT : STAT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign vld_o = vld_q;
  assign res_o = res_q;

endmodule

FILE: rtl/complex_integer_alu.sv
// Top level of the complex integer ALU: front end, divider pipeline, output stage.
// Depends on cia_pkg, cia_front, cia_div and cia_sat.
//
//   channel   ports                     transfer
//   input     start_i, busy_o, item_i   start_i high while busy_o low
//   result    res_valid_o, res_o        every cycle res_valid_o is high
//
// One item enters per cycle; each result is strobed on res_valid_o once its item has passed the
// input, product, sum/magnitude, divider and output registers, in that order.
// Most of the latency comes from the 32-stage divider, which every item passes through.
// busy_o is always low: the pipeline never stalls and the receiver cannot stall.
// Reset clears all valid bits; no result is lost or repeated.
module complex_integer_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  cia_pkg::cia_in_t  item_i,
  output logic              res_valid_o,
  output cia_pkg::cia_out_t res_o
);
  import cia_pkg::*;

  logic       front_vld, div_vld;
  sm_item_t   sm;
  quot_item_t quot;

  assign busy_o = 1'b0;

  cia_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start_i && !busy_o),
    .item_i (item_i),
    .vld_o  (front_vld),
    .sm_o   (sm)
  );

  cia_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (front_vld),
    .sm_i   (sm),
    .vld_o  (div_vld),
    .quot_o (quot)
  );

  cia_sat u_sat (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (div_vld),
    .quot_i (quot),
    .vld_o  (res_valid_o),
    .res_o  (res_o)
  );

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.status != 2'd3))
    else $error("illegal status code");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == STAT_DZ) |->
      (res_o.res_real == '0 && res_o.res_imag == '0))
    else $error("divide-by-zero result with nonzero parts");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == STAT_SAT) |->
      (res_o.res_real == {1'b0, {(ResW-1){1'b1}}} ||
       res_o.res_imag == {1'b0, {(ResW-1){1'b1}}}))
    else $error("saturated status without a clamped part");

endmodule

FILE: sim/tb_complex_integer_alu.sv
// Self-checking testbench of the complex integer ALU: directed table, then random items.
// Depends on cia_pkg and complex_integer_alu; checks use typed rows or a local predictor.
`timescale 1ns / 1ps
module tb_complex_integer_alu;
  import cia_pkg::*;

  localparam int Latency  = 36;
  localparam int CycleCap = 200000;
  localparam int NumRand  = 600;
  localparam int NumDir   = 22;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start_i = 1'b0;
  logic     busy_o;
  cia_in_t  item_i = '0;
  logic     res_valid_o;
  cia_out_t res_o;

  cia_out_t expected_q[$];
  int       errors = 0;
  int       cycles = 0;
  int       sender_idle = 0;  // percent of cycles the sender holds off

  complex_integer_alu dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .res_valid_o, .res_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Clamp an exact value to 32 bits and raise the saturation flag if needed.
  function automatic logic signed [31:0] clamp32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic cia_out_t alu_predict(cia_in_t it);
    cia_out_t r;
    longint ar, ai, br, bi, s, re, im, den;
    bit sat, dz;
    ar = it.a_real; ai = it.a_imag; br = it.b_real; bi = it.b_imag; s = it.scalar;
    re = 0; im = 0; sat = 0; dz = 0;
    case (it.func)
      FUNC_ADD: begin re = ar + br; im = ai + bi; end
      FUNC_SUB: begin re = ar - br; im = ai - bi; end
      FUNC_MUL: begin re = ar * br - ai * bi; im = ar * bi + br * ai; end
      FUNC_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) dz = 1;
        else begin
          // SystemVerilog division truncates toward zero, as required.
          re = (ar * br + ai * bi) / den;
          im = (br * ai - ar * bi) / den;
        end
      end
      FUNC_SMUL: begin re = s * ar; im = s * ai; end
      FUNC_SDIV: begin
        if (s == 0) dz = 1;
        else begin re = ar / s; im = ai / s; end
      end
      default: ;
    endcase
    r.res_real = clamp32(re, sat);
    r.res_imag = clamp32(im, sat);
    r.status = dz ? STAT_DZ : (sat ? STAT_SAT : STAT_OK);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // Result checker: every strobed result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    cia_out_t want;
    cycles <= cycles + 1;
    if (rst_ni && res_valid_o) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", res_o.res_real, '0);
      end else begin
        want = expected_q.pop_front();
        if (res_o.res_real !== want.res_real)
          report_mismatch("res_real", res_o.res_real, want.res_real);
        if (res_o.res_imag !== want.res_imag)
          report_mismatch("res_imag", res_o.res_imag, want.res_imag);
        if (res_o.status !== want.status)
          report_mismatch("status", res_o.status, want.status);
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleCap) begin
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
    end
  end

  typedef struct {
    cia_in_t  it;
    bit       typed;
    cia_out_t want;
  } dir_row_t;

  dir_row_t dir_tab[NumDir];

  function automatic dir_row_t mk(logic [2:0] f, int ar, int ai, int br, int bi, int s,
                                  bit typed = 0, int wr = 0, int wi = 0,
                                  status_e st = STAT_OK);
    dir_row_t d;
    d.it = '{func: f, a_real: ar[15:0], a_imag: ai[15:0], b_real: br[15:0],
             b_imag: bi[15:0], scalar: s[15:0]};
    d.typed = typed;
    d.want = '{res_real: wr, res_imag: wi, status: st};
    return d;
  endfunction

  // Drive one item; holds start_i until the transfer happens.
  task automatic send_item(cia_in_t it, cia_out_t want);
    while ($urandom_range(99) < sender_idle) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_q.push_back(want);
  endtask

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(7)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    cia_in_t it;
    int wait_cnt;
    dir_tab = '{
      mk(FUNC_ADD, 0, 0, 0, 0, 0, 1, 0, 0, STAT_OK),
      mk(FUNC_ADD, 32767, -32768, 32767, -32768, 0, 1, 65534, -65536, STAT_OK),
      mk(FUNC_SUB, -32768, 32767, 32767, -32768, 0, 1, -65535, 65535, STAT_OK),
      mk(FUNC_MUL, -32768, -32768, -32768, 32767, 0),
      mk(FUNC_MUL, -32768, 0, -32768, 0, 0, 1, 1073741824, 0, STAT_OK),
      mk(FUNC_MUL, -32768, -32768, -32768, -32768, 0),
      mk(FUNC_MUL, 3, 4, 5, -6, 0),
      mk(FUNC_DIV, 100, 50, 0, 0, 7, 1, 0, 0, STAT_DZ),
      mk(FUNC_DIV, -32768, -32768, 1, 0, 0, 1, -32768, -32768, STAT_OK),
      mk(FUNC_DIV, 32767, -32768, -32768, -32768, 0),
      mk(FUNC_DIV, -7, 9, 2, -3, 0),
      mk(FUNC_DIV, 1, 1, 32767, 32767, 0, 1, 0, 0, STAT_OK),
      mk(FUNC_SMUL, -32768, 32767, 0, 0, -32768, 1, 1073741824, -1073709056, STAT_OK),
      mk(FUNC_SMUL, 5, -5, 0, 0, 32767),
      mk(FUNC_SDIV, 10, 10, 0, 0, 0, 1, 0, 0, STAT_DZ),
      mk(FUNC_SDIV, -32768, 32767, 0, 0, -1, 1, 32768, -32767, STAT_OK),
      mk(FUNC_SDIV, -7, 7, 0, 0, 2, 1, -3, 3, STAT_OK),
      mk(FUNC_SDIV, 32767, -32768, -1, -1, 32767),
      mk(3'd6, 123, -4, 5, 6, 7, 1, 0, 0, STAT_OK),
      mk(3'd7, -1, -1, -1, -1, -1, 1, 0, 0, STAT_OK),
      mk(FUNC_ADD, -1, -1, -1, -1, -1, 1, -2, -2, STAT_OK),
      mk(FUNC_SUB, 0, 0, -32768, -32768, 0, 1, 32768, 32768, STAT_OK)
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      send_item(dir_tab[i].it, dir_tab[i].typed ? dir_tab[i].want : alu_predict(dir_tab[i].it));

    for (int n = 0; n < NumRand; n++) begin
      case (n / 150)
        0: sender_idle = 0;
        1: sender_idle = 76;
        2: sender_idle = 16;
        default: sender_idle = (n % 100 < 50) ? 0 : 76;
      endcase
      if (n == 300) begin
        // Let the pipeline drain completely before continuing.
        start_i <= 1'b0;
        wait_cnt = 0;
        while (expected_q.size() != 0 && wait_cnt < 10 * Latency) begin
          @(posedge clk_i);
          wait_cnt++;
        end
      end
      it.func = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6))
                                          : 3'($urandom_range(5));
      it.a_real = rand_operand();
      it.a_imag = rand_operand();
      it.b_real = ($urandom_range(9) == 0) ? 16'h0 : rand_operand();
      it.b_imag = ($urandom_range(9) == 0) ? 16'h0 : rand_operand();
      it.scalar = ($urandom_range(9) == 0) ? 16'h0 : rand_operand();
      send_item(it, alu_predict(it));
    end
    start_i <= 1'b0;

    wait_cnt = 0;
    while (expected_q.size() != 0 && wait_cnt < 20 * Latency) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (2 * Latency) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $display("%0d results never arrived", expected_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
